### hw/rtl/dkp_pkg.sv
package dkp_pkg;

    localparam int THRESH_W         = 16;
    localparam int DEF_COUNT_BITS   = 16;
    localparam int CFG_IDX_W        = 1;
    localparam int EVENT_W          = 3;

    localparam logic [THRESH_W-1:0] SHORT_TICKS_RESET = 16'd20;
    localparam logic [THRESH_W-1:0] LONG_TICKS_RESET  = 16'd400;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHORT_PRESS_TICKS = 1'b0,
        REG_LONG_PRESS_TICKS  = 1'b1
    } cfg_reg_t;

    // per-key event
    typedef enum logic [1:0] {
        KEV_NONE  = 2'd0,
        KEV_SHORT = 2'd1,
        KEV_LONG  = 2'd2
    } key_ev_t;

    // combined event code on the output
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 3'd0,
        EV_K1_SHORT  = 3'd1,
        EV_K1_LONG   = 3'd2,
        EV_K2_SHORT  = 3'd3,
        EV_K2_LONG   = 3'd4
    } event_t;

    typedef struct packed {
        logic [THRESH_W-1:0] short_ticks;
        logic [THRESH_W-1:0] long_ticks;
    } thresh_t;

    typedef struct packed {
        logic locked;
        logic armed;
    } key_status_t;

endpackage

### hw/rtl/dual_key_short_long_press.sv
// Path: an input transaction passes through the input register and then the result register
// before its result transaction is offered on out_valid.
// Throughput: one scan tick per cycle while the result is not held; each key's counter/lock/armed
// update is a single increment and compare feeding the result register. A held
// result stalls both stages; the input register keeps its transaction and takes a new one
// while empty or advancing. Reset clears key state, valid flags and loads thresholds 20 and 400.
module dual_key_short_long_press #(
    parameter int COUNT_BITS = dkp_pkg::DEF_COUNT_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            key_one_level,
    input  logic                            key_two_level,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [dkp_pkg::EVENT_W-1:0]     key_event,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dkp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dkp_pkg::THRESH_W-1:0]    cfg_data
);
    import dkp_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        lvl_one_reg;
    logic        lvl_two_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    event_t      event_reg;
    event_t      event_next;
    logic        advance;
    logic        step;
    thresh_t     thr;
    key_ev_t     ev_one;
    key_ev_t     ev_two;
    key_status_t st_one;
    key_status_t st_two;

    assign cfg_ready = 1'b1;

    // stage 1 moves to the result register when it is empty or being drained
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign step     = s1_valid_reg && advance;

    dkp_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .thr      (thr)
    );

    dkp_key_scan #(.COUNT_BITS(COUNT_BITS)) u_key_one (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (step),
        .level  (lvl_one_reg),
        .thr    (thr),
        .ev     (ev_one),
        .status (st_one)
    );

    dkp_key_scan #(.COUNT_BITS(COUNT_BITS)) u_key_two (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (step),
        .level  (lvl_two_reg),
        .thr    (thr),
        .ev     (ev_two),
        .status (st_two)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_ready)
        begin
            s1_valid_next = in_valid;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    // key two overrides key one
    always_comb
    begin
        priority if (ev_two == KEV_LONG)
            event_next = EV_K2_LONG;
        else if (ev_two == KEV_SHORT)
            event_next = EV_K2_SHORT;
        else if (ev_one == KEV_LONG)
            event_next = EV_K1_LONG;
        else if (ev_one == KEV_SHORT)
            event_next = EV_K1_SHORT;
        else
            event_next = EV_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            lvl_one_reg <= key_one_level;
            lvl_two_reg <= key_two_level;
        end
        if (step)
        begin
            event_reg <= event_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign key_event = event_reg;

    // a locked key is never armed
    assert property (@(posedge clk) disable iff (!rst_n)
        !(st_one.locked && st_one.armed) && !(st_two.locked && st_two.armed))
        else $error("key locked while short press armed");

    // input stalls only when both stages are full and the result is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a full pipeline");

    // a long press of key two leaves it locked
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && ev_two == KEV_LONG) |=> st_two.locked)
        else $error("key two not locked after long press");

    // result code stays in its legal range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (key_event <= EV_K2_LONG))
        else $error("illegal event code");

endmodule

### hw/rtl/dkp_cfg_regs.sv
module dkp_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [dkp_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [dkp_pkg::THRESH_W-1:0]    wr_data,
    output dkp_pkg::thresh_t                thr
);
    import dkp_pkg::*;

    thresh_t thr_reg;
    thresh_t thr_next;

    always_comb
    begin
        thr_next = thr_reg;
        if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_index))
                REG_SHORT_PRESS_TICKS: thr_next.short_ticks = wr_data;
                REG_LONG_PRESS_TICKS:  thr_next.long_ticks  = wr_data;
                default:               thr_next = thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.short_ticks <= SHORT_TICKS_RESET;
            thr_reg.long_ticks  <= LONG_TICKS_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    assign thr = thr_reg;

endmodule

### hw/rtl/dkp_key_scan.sv
module dkp_key_scan #(
    parameter int COUNT_BITS = dkp_pkg::DEF_COUNT_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    level,
    input  dkp_pkg::thresh_t        thr,
    output dkp_pkg::key_ev_t        ev,
    output dkp_pkg::key_status_t    status
);
    import dkp_pkg::*;

    localparam int CMP_W = (COUNT_BITS > THRESH_W) ? COUNT_BITS : THRESH_W;

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  locked_reg;
    logic                  locked_next;
    logic                  armed_reg;
    logic                  armed_next;
    logic [COUNT_BITS-1:0] count_inc;
    logic [CMP_W-1:0]      count_cmp;
    logic                  past_short;
    logic                  past_long;

    // saturate instead of wrapping
    assign count_inc  = (count_reg == {COUNT_BITS{1'b1}}) ? count_reg
                                                          : count_reg + 1'b1;
    assign count_cmp  = CMP_W'(count_inc);
    assign past_short = count_cmp > CMP_W'(thr.short_ticks);
    assign past_long  = count_cmp > CMP_W'(thr.long_ticks);

    always_comb
    begin
        count_next  = count_reg;
        locked_next = locked_reg;
        armed_next  = armed_reg;
        ev          = KEV_NONE;
        priority if (level)
        begin
            // released: clear, report short press if armed
            count_next  = '0;
            locked_next = 1'b0;
            armed_next  = 1'b0;
            if (armed_reg)
            begin
                ev = KEV_SHORT;
            end
        end
        else if (!locked_reg)
        begin
            count_next = count_inc;
            if (past_short)
            begin
                armed_next = 1'b1;
            end
            // long press wins over short in the same tick
            if (past_long)
            begin
                armed_next  = 1'b0;
                count_next  = '0;
                locked_next = 1'b1;
                ev          = KEV_LONG;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            locked_reg <= 1'b0;
            armed_reg  <= 1'b0;
        end
        else if (en)
        begin
            count_reg  <= count_next;
            locked_reg <= locked_next;
            armed_reg  <= armed_next;
        end
    end

    assign status.locked = locked_reg;
    assign status.armed  = armed_reg;

endmodule
